FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on every clock edge outside reset
`define CLFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checks that a condition is followed by another in the next cycle
`define CLFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/clfs_pkg.sv
package clfs_pkg;

  localparam int unsigned MAX_WIDTH     = 256;
  localparam int unsigned MAX_BAND      = 64;
  localparam int unsigned RED_MIN       = 200;
  localparam int unsigned RED_OTHER_MAX = 30;
  localparam int unsigned WINDOW_HALF   = 10;
  localparam int unsigned COUNT_MAX     = 32767;

  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned BASE_W     = 15;
  localparam int unsigned PROD_W     = GAIN_W + CNT_W;
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned SPD_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_BAND_ROWS      = 3'd2,
    CFG_DARK_THRESHOLD = 3'd3,
    CFG_SPLIT_COLUMN   = 3'd4,
    CFG_STOP_ROW_MIN   = 3'd5,
    CFG_STEER_GAIN     = 3'd6,
    CFG_BASE_SPEED     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pix_col;
    logic [7:0] pix_row;
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
    logic       frame_last;
  } pix_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] left_speed;
    logic signed [SPD_W-1:0] right_speed;
    logic                    stop_seen;
  } spd_t;

  typedef struct packed {
    logic acc_en;
    logic snap;
    logic mul_ld;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_pix;
  } sts_t;

endpackage

FILE: rtl/clfs_ifs.sv
interface clfs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_col;
  logic [7:0] pix_row;
  logic [7:0] chan_red;
  logic [7:0] chan_green;
  logic [7:0] chan_blue;
  logic       frame_last;

  modport source (output valid, pix_col, pix_row, chan_red, chan_green, chan_blue,
                  frame_last, input ready);
  modport sink (input valid, pix_col, pix_row, chan_red, chan_green, chan_blue,
                frame_last, output ready);
endinterface

interface clfs_spd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic               stop_seen;

  modport source (output valid, left_speed, right_speed, stop_seen, input ready);
  modport sink (input valid, left_speed, right_speed, stop_seen, output ready);
endinterface

FILE: rtl/clfs_dp.sv
`include "assert_macros.svh"

module clfs_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [clfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  clfs_pkg::pix_t                  pix,
  input  clfs_pkg::cmd_t                  cmd,
  output clfs_pkg::sts_t                  sts,
  output clfs_pkg::spd_t                  spd
);
  import clfs_pkg::*;

  logic [8:0]        frame_width_r, frame_height_r, split_column_r;
  logic [6:0]        band_rows_r;
  logic [7:0]        dark_threshold_r, stop_row_min_r;
  logic [GAIN_W-1:0] steer_gain_r;
  logic [BASE_W-1:0] base_speed_r;

  logic signed [SUM_W-1:0] sum_r, sum_nxt, snap_sum_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, snap_cnt_r;
  logic                    stop_r, stop_nxt, snap_stop_r;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W-1:0]  rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [CNT_W-1:0]  sum_mag;
  logic              rem_ge;

  logic [9:0] w_eff, mid, col_x, row_x, h_x;
  logic [6:0] band_eff;
  logic       in_frame, is_red, in_win, is_dark, stop_hit, dark_hit;

  logic signed [33:0] turn, base_s, left_raw, right_raw, left_c, right_c;
  logic               neg;
  spd_t               spd_r;
  logic signed [16:0] sum_ext, cnt_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= 9'd104;
      frame_height_r   <= 9'd96;
      band_rows_r      <= 7'd25;
      dark_threshold_r <= 8'd80;
      split_column_r   <= 9'd52;
      stop_row_min_r   <= 8'd65;
      steer_gain_r     <= 16'd2048;
      base_speed_r     <= 15'd1536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[8:0];
        CFG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata[8:0];
        CFG_BAND_ROWS:      band_rows_r      <= cfg_wdata[6:0];
        CFG_DARK_THRESHOLD: dark_threshold_r <= cfg_wdata[7:0];
        CFG_SPLIT_COLUMN:   split_column_r   <= cfg_wdata[8:0];
        CFG_STOP_ROW_MIN:   stop_row_min_r   <= cfg_wdata[7:0];
        CFG_STEER_GAIN:     steer_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_BASE_SPEED:     base_speed_r     <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel classification
  always_comb begin
    w_eff    = ({1'b0, frame_width_r} > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH)
                                                        : {1'b0, frame_width_r};
    band_eff = (band_rows_r > 7'(MAX_BAND)) ? 7'(MAX_BAND) : band_rows_r;
    mid      = w_eff >> 1;
    col_x    = {2'b00, pix.pix_col};
    row_x    = {2'b00, pix.pix_row};
    h_x      = {1'b0, frame_height_r};
    in_frame = (col_x < w_eff) && (row_x < h_x) && ((row_x + {3'b000, band_eff}) >= h_x);
    is_red   = (pix.chan_red > 8'(RED_MIN)) && (pix.chan_green < 8'(RED_OTHER_MAX))
               && (pix.chan_blue < 8'(RED_OTHER_MAX));
    in_win   = ((col_x + 10'(WINDOW_HALF)) > mid) && (col_x < (mid + 10'(WINDOW_HALF)))
               && (pix.pix_row > stop_row_min_r);
    is_dark  = (pix.chan_red < dark_threshold_r) && (pix.chan_green < dark_threshold_r)
               && (pix.chan_blue < dark_threshold_r);
    stop_hit = in_frame && is_red && in_win;
    dark_hit = in_frame && !is_red && is_dark && (cnt_r != CNT_W'(COUNT_MAX));

    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r | stop_hit;
    if (dark_hit) begin
      sum_nxt = ({1'b0, pix.pix_col} < split_column_r) ? sum_r - SUM_W'(1) : sum_r + SUM_W'(1);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // frame accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else if (cmd.acc_en) begin
      if (cmd.snap) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        stop_r <= 1'b0;
      end else begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      snap_sum_r  <= sum_nxt;
      snap_cnt_r  <= cnt_nxt;
      snap_stop_r <= stop_nxt;
    end
  end

  // gain product, then restoring divide one quotient bit per cycle
  assign neg     = snap_sum_r[SUM_W-1];
  assign sum_mag = neg ? CNT_W'(-snap_sum_r) : CNT_W'(snap_sum_r);
  assign rem_sh  = {rem_r, quo_r[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, snap_cnt_r};

  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      quo_r <= steer_gain_r * sum_mag;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[PROD_W-2:0], rem_ge};
      rem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, snap_cnt_r}) : rem_sh[CNT_W-1:0];
    end
  end

  // speed mix and clamp
  always_comb begin
    base_s    = 34'($unsigned(base_speed_r));
    turn      = 34'($unsigned(quo_r));
    if (snap_cnt_r == '0) begin
      turn = '0;
    end else if (neg) begin
      turn = -turn;
    end
    left_raw  = base_s - turn;
    right_raw = base_s + turn;
    left_c    = left_raw;
    right_c   = right_raw;
    if (left_raw > base_s) begin
      left_c = base_s;
    end else if (left_raw < -base_s) begin
      left_c = -base_s;
    end
    if (right_raw > base_s) begin
      right_c = base_s;
    end else if (right_raw < -base_s) begin
      right_c = -base_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      spd_r.stop_seen <= snap_stop_r;
      if (snap_stop_r) begin
        spd_r.left_speed  <= '0;
        spd_r.right_speed <= '0;
      end else begin
        spd_r.left_speed  <= left_c[SPD_W-1:0];
        spd_r.right_speed <= right_c[SPD_W-1:0];
      end
    end
  end

  assign spd          = spd_r;
  assign sts.last_pix = pix.frame_last;

  assign sum_ext = 17'(sum_r);
  assign cnt_ext = $signed({2'b00, cnt_r});

  `CLFS_ASSERT(a_sum_within_cnt, (sum_ext <= cnt_ext) && (-sum_ext <= cnt_ext), "side sum exceeds dark count")

endmodule

FILE: rtl/clfs_ctrl.sv
`include "assert_macros.svh"

module clfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  clfs_pkg::sts_t sts,
  output clfs_pkg::cmd_t cmd
);
  import clfs_pkg::*;

  typedef enum logic [3:0] {
    S_ACC  = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               st_r, st_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 div_last;

  assign div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign in_ready = st_r == S_ACC;

  always_comb begin
    st_nxt       = st_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    cmd.acc_en   = in_valid && in_ready;
    cmd.snap     = cmd.acc_en && sts.last_pix;
    unique case (st_r)
      S_ACC: begin
        if (cmd.snap) begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_ld  = 1'b1;
        div_cnt_nxt = '0;
        st_nxt      = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          st_nxt       = S_ACC;
        end
      end
      default: st_nxt = S_ACC;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_ACC;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CLFS_ASSERT_NEXT(a_last_starts_mul, cmd.snap, st_r == S_MUL, "frame end did not start multiply")
  `CLFS_ASSERT_NEXT(a_div_ends, (st_r == S_DIV) && div_last, st_r == S_EMIT, "divide overran")
  `CLFS_ASSERT(a_valid_from_emit, $rose(out_valid_r) |-> ($past(st_r) == S_EMIT), "result without emit")

endmodule

FILE: rtl/camera_line_follow_speed.sv
// camera_line_follow_speed
// in_pix carries one camera pixel per transfer: column, row, three colour
// channels and a frame_last flag. out_spd carries one result per frame:
// left and right wheel speeds (signed Q7.8) and a stop flag.
// cfg_we / cfg_idx / cfg_wdata write the eight setup registers; write them
// only while no frame result is pending.
// Pixels are taken one per cycle while in_pix.ready is high. The transfer
// that carries frame_last starts the frame-end pass: the gain multiply,
// the bit-serial restoring divider, then the load of the output register,
// which waits while a previous result is still stalled on out_spd.
// in_pix.ready stays low from that transfer until the output load.
// The result sits in an output register, so pixels of the next frame keep
// flowing while out_spd is stalled; only the next frame end waits for it.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// frame sums and drops out_spd.valid.
module camera_line_follow_speed (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [clfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [clfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  clfs_pix_if.sink                        in_pix,
  clfs_spd_if.source                      out_spd
);
  import clfs_pkg::*;

  pix_t pix;
  spd_t spd;
  cmd_t cmd;
  sts_t sts;

  assign pix.pix_col    = in_pix.pix_col;
  assign pix.pix_row    = in_pix.pix_row;
  assign pix.chan_red   = in_pix.chan_red;
  assign pix.chan_green = in_pix.chan_green;
  assign pix.chan_blue  = in_pix.chan_blue;
  assign pix.frame_last = in_pix.frame_last;

  clfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_spd.valid),
    .out_ready (out_spd.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clfs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pix       (pix),
    .cmd       (cmd),
    .sts       (sts),
    .spd       (spd)
  );

  assign out_spd.left_speed  = spd.left_speed;
  assign out_spd.right_speed = spd.right_speed;
  assign out_spd.stop_seen   = spd.stop_seen;

endmodule

FILE: dv/camera_line_follow_speed_tb.sv
`timescale 1ns / 100ps

module camera_line_follow_speed_tb;
  import clfs_pkg::*;

  localparam int FRAME_END_CYCLES = 33;
  localparam int SETTLE_CYCLES    = FRAME_END_CYCLES + 8;
  localparam int IDLE_LIMIT       = 4000;
  localparam int HOLD_CYCLES      = 400;
  localparam int RAND_PHASES      = 8;
  localparam int PHASE_ITEMS      = 56;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [6:0]  band;
    logic [7:0]  thresh;
    logic [8:0]  split;
    logic [7:0]  stop_row;
    logic [15:0] gain;
    logic [14:0] base;
  } track_cfg_t;

  localparam track_cfg_t RESET_SETUP =
    '{9'd104, 9'd96, 7'd25, 8'd80, 9'd52, 8'd65, 16'd2048, 15'd1536};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  clfs_pix_if pix_ch ();
  clfs_spd_if spd_ch ();

  camera_line_follow_speed dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_ch),
    .out_spd   (spd_ch)
  );

  track_cfg_t              setup_now  = RESET_SETUP;
  logic signed [SUM_W-1:0] side_sum   = '0;
  logic [CNT_W-1:0]        dark_count = '0;
  logic                    stop_flag  = 1'b0;
  spd_t                    frame_speeds_q[$];
  int                      mismatch_cnt   = 0;
  bit                      src_gaps_on    = 1'b1;
  bit                      sink_stalls_on = 1'b1;
  int                      sink_hold_len  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line/stop accumulation per pixel, wheel speeds at frame end
  function automatic void track_pixel(pix_t p);
    int     w, h, band, mid, col, row, thr;
    longint base, turn, lft, rgt;
    spd_t   s;
    w = int'(setup_now.width);
    if (w > int'(MAX_WIDTH)) w = MAX_WIDTH;
    h = int'(setup_now.height);
    band = int'(setup_now.band);
    if (band > int'(MAX_BAND)) band = MAX_BAND;
    mid = w / 2;
    col = int'(p.pix_col);
    row = int'(p.pix_row);
    thr = int'(setup_now.thresh);
    if (col < w && row < h && row >= h - band) begin
      if (p.chan_red > RED_MIN && p.chan_green < RED_OTHER_MAX &&
          p.chan_blue < RED_OTHER_MAX) begin
        if (col > mid - int'(WINDOW_HALF) && col < mid + int'(WINDOW_HALF) &&
            row > int'(setup_now.stop_row))
          stop_flag = 1'b1;
      end else if (int'(p.chan_red) < thr && int'(p.chan_green) < thr &&
                   int'(p.chan_blue) < thr) begin
        if (dark_count < COUNT_MAX) begin
          if (col < int'(setup_now.split)) side_sum = side_sum - 16'sd1;
          else side_sum = side_sum + 16'sd1;
          dark_count = dark_count + 1'b1;
        end
      end
    end
    if (p.frame_last) begin
      if (stop_flag) begin
        s.left_speed  = '0;
        s.right_speed = '0;
        s.stop_seen   = 1'b1;
      end else begin
        base = longint'(setup_now.base);
        turn = 0;
        if (dark_count != 0)
          turn = longint'(setup_now.gain) * longint'(side_sum) / longint'(dark_count);
        lft = base - turn;
        rgt = base + turn;
        if (lft > base) lft = base;
        else if (lft < -base) lft = -base;
        if (rgt > base) rgt = base;
        else if (rgt < -base) rgt = -base;
        s.left_speed  = lft[SPD_W-1:0];
        s.right_speed = rgt[SPD_W-1:0];
        s.stop_seen   = 1'b0;
      end
      frame_speeds_q.push_back(s);
      side_sum   = '0;
      dark_count = '0;
      stop_flag  = 1'b0;
    end
  endfunction

  function automatic pix_t pixel_at(int col, int row, int r, int g, int b, bit last);
    pix_t p;
    p.pix_col    = 8'(col);
    p.pix_row    = 8'(row);
    p.chan_red   = 8'(r);
    p.chan_green = 8'(g);
    p.chan_blue  = 8'(b);
    p.frame_last = last;
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(19, 0);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic track_cfg_t random_setup();
    track_cfg_t c;
    c.width    = ($urandom_range(7, 0) == 0) ? 9'($urandom_range(511, 257))
                                             : 9'($urandom_range(256, 1));
    c.height   = ($urandom_range(7, 0) == 0) ? 9'($urandom_range(511, 257))
                                             : 9'($urandom_range(256, 1));
    c.band     = ($urandom_range(7, 0) == 0) ? 7'($urandom_range(127, 65))
                                             : 7'($urandom_range(64, 1));
    c.thresh   = 8'($urandom_range(255, 0));
    c.split    = ($urandom_range(7, 0) == 0) ? 9'($urandom_range(511, 257))
                                             : 9'($urandom_range(256, 0));
    c.stop_row = 8'($urandom_range(255, 0));
    c.gain     = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 0))
                                             : 16'($urandom_range(4096, 0));
    c.base     = ($urandom_range(3, 0) == 0) ? 15'($urandom_range(32767, 0))
                                             : 15'($urandom_range(4096, 0));
    return c;
  endfunction

  // mostly pixels inside the examined band, some anywhere
  function automatic pix_t frame_pixel(track_cfg_t c, bit last);
    pix_t p;
    int   kind, w, mid, lo, hi, thr, col_lo, col_hi;
    p = pixel_at($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0),
                 $urandom_range(255, 0), $urandom_range(255, 0), last);
    kind = $urandom_range(9, 0);
    w = int'(c.width);
    if (w > int'(MAX_WIDTH)) w = MAX_WIDTH;
    hi = int'(c.height) - 1;
    if (hi > 255) hi = 255;
    lo = int'(c.height) - ((int'(c.band) > int'(MAX_BAND)) ? int'(MAX_BAND) : int'(c.band));
    if (lo < 0) lo = 0;
    if (kind == 0 || lo > hi || w == 0) return p;
    mid = w / 2;
    col_lo = 0;
    col_hi = w - 1;
    if (kind >= 4 && kind <= 7) begin
      col_lo = (mid > int'(WINDOW_HALF)) ? mid - int'(WINDOW_HALF) - 1 : 0;
      col_hi = mid + int'(WINDOW_HALF) + 1;
      if (col_hi > w - 1) col_hi = w - 1;
    end
    p.pix_col = 8'($urandom_range(col_hi, col_lo));
    p.pix_row = 8'($urandom_range(hi, lo));
    thr = int'(c.thresh);
    if (kind <= 5) begin
      if (thr > 0) begin
        p.chan_red   = 8'($urandom_range(thr - 1, 0));
        p.chan_green = 8'($urandom_range(thr - 1, 0));
        p.chan_blue  = 8'($urandom_range(thr - 1, 0));
        if ($urandom_range(7, 0) == 0) p.chan_blue = c.thresh;
      end
    end else if (kind <= 7) begin
      p.chan_red   = 8'($urandom_range(255, RED_MIN - 2));
      p.chan_green = 8'($urandom_range(RED_OTHER_MAX + 2, 0));
      p.chan_blue  = 8'($urandom_range(RED_OTHER_MAX + 2, 0));
    end
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.pix_col    <= p.pix_col;
    pix_ch.pix_row    <= p.pix_row;
    pix_ch.chan_red   <= p.chan_red;
    pix_ch.chan_green <= p.chan_green;
    pix_ch.chan_blue  <= p.chan_blue;
    pix_ch.frame_last <= p.frame_last;
    @(posedge clk);
    while (pix_ch.ready !== 1'b1) @(posedge clk);
    track_pixel(p);
  endtask

  task automatic wait_results_done();
    pix_ch.valid <= 1'b0;
    while (frame_speeds_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setup(track_cfg_t c);
    wait_results_done();
    cfg_we <= 1'b1;
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(c.width));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(c.height));
    write_reg(CFG_BAND_ROWS, CFG_DATA_W'(c.band));
    write_reg(CFG_DARK_THRESHOLD, CFG_DATA_W'(c.thresh));
    write_reg(CFG_SPLIT_COLUMN, CFG_DATA_W'(c.split));
    write_reg(CFG_STOP_ROW_MIN, CFG_DATA_W'(c.stop_row));
    write_reg(CFG_STEER_GAIN, CFG_DATA_W'(c.gain));
    write_reg(CFG_BASE_SPEED, CFG_DATA_W'(c.base));
    cfg_we <= 1'b0;
    setup_now = c;
  endtask

  task automatic test_default_frame();
    send_pixel(pixel_at(10, 80, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(52, 95, 79, 79, 79, 1'b0));
    send_pixel(pixel_at(60, 90, 80, 0, 0, 1'b0));
    send_pixel(pixel_at(103, 71, 5, 6, 7, 1'b0));
    send_pixel(pixel_at(51, 72, 0, 79, 0, 1'b1));
    // no line pixels at all
    send_pixel(pixel_at(255, 255, 0, 0, 0, 1'b1));
  endtask

  task automatic test_stop_line();
    send_pixel(pixel_at(53, 66, 255, 0, 0, 1'b0));
    send_pixel(pixel_at(30, 90, 0, 0, 0, 1'b1));
    // red just outside the window, and a nearly red pixel
    send_pixel(pixel_at(42, 90, 255, 0, 0, 1'b0));
    send_pixel(pixel_at(62, 90, 255, 0, 0, 1'b0));
    send_pixel(pixel_at(61, 95, 200, 29, 29, 1'b1));
    send_pixel(pixel_at(44, 95, 201, 29, 29, 1'b1));
  endtask

  task automatic test_outside_frame();
    apply_setup('{9'd40, 9'd50, 7'd20, 8'd80, 9'd20, 8'd35, 16'd512, 15'd1000});
    send_pixel(pixel_at(40, 40, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(10, 50, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(10, 29, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(39, 49, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(19, 30, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(20, 35, 255, 0, 0, 1'b0));
    send_pixel(pixel_at(255, 255, 0, 0, 0, 1'b1));
  endtask

  task automatic test_register_extremes();
    apply_setup('{9'd1, 9'd1, 7'd1, 8'd255, 9'd0, 8'd0, 16'd65535, 15'd32767});
    send_pixel(pixel_at(0, 0, 255, 255, 255, 1'b0));
    send_pixel(pixel_at(0, 0, 254, 254, 254, 1'b1));
    // band taller than the frame, zero gain and zero base speed
    apply_setup('{9'd256, 9'd10, 7'd64, 8'd255, 9'd256, 8'd255, 16'd0, 15'd0});
    send_pixel(pixel_at(255, 0, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(128, 5, 255, 0, 0, 1'b0));
    send_pixel(pixel_at(0, 9, 0, 0, 0, 1'b1));
    // oversized width and band registers
    apply_setup('{9'd511, 9'd100, 7'd127, 8'd1, 9'd128, 8'd0, 16'd256, 15'd100});
    send_pixel(pixel_at(10, 35, 0, 0, 0, 1'b0));
    send_pixel(pixel_at(255, 36, 0, 0, 0, 1'b1));
    send_pixel(pixel_at(137, 99, 255, 0, 0, 1'b1));
    send_pixel(pixel_at(128, 99, 255, 0, 0, 1'b1));
    apply_setup('{9'd104, 9'd96, 7'd25, 8'd0, 9'd52, 8'd65, 16'd2048, 15'd1536});
    send_pixel(pixel_at(52, 90, 0, 0, 0, 1'b1));
  endtask

  task automatic test_output_backpressure();
    apply_setup(RESET_SETUP);
    sink_hold_len = HOLD_CYCLES;
    for (int f = 0; f < 6; f++)
      for (int i = 0; i < 4; i++) send_pixel(frame_pixel(RESET_SETUP, i == 3));
    wait_results_done();
    for (int f = 0; f < 2; f++)
      for (int i = 0; i < 3; i++) send_pixel(frame_pixel(RESET_SETUP, i == 2));
  endtask

  task automatic test_random_frames();
    track_cfg_t c;
    int         flen, sent;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      c = (ph == 0) ? RESET_SETUP : random_setup();
      apply_setup(c);
      src_gaps_on    = ph[0];
      sink_stalls_on = ph[1];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        flen = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < flen; i++) send_pixel(frame_pixel(c, i == flen - 1));
        sent += flen;
      end
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin : result_sink
    int n;
    spd_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = 0;
      if (sink_hold_len > 0) begin
        n = sink_hold_len;
        sink_hold_len = 0;
      end else if (sink_stalls_on) begin
        n = pick_gap();
      end
      if (n > 0) begin
        spd_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      spd_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    spd_t want;
    if (rst_n === 1'b1 && spd_ch.valid === 1'b1 && spd_ch.ready === 1'b1) begin
      if (frame_speeds_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= SHOWN_MISMATCHES)
          $display("%0t: unexpected speed transfer L=%0d R=%0d stop=%0b", $time,
                   spd_ch.left_speed, spd_ch.right_speed, spd_ch.stop_seen);
      end else begin
        want = frame_speeds_q.pop_front();
        if (spd_ch.left_speed !== want.left_speed || spd_ch.right_speed !== want.right_speed ||
            spd_ch.stop_seen !== want.stop_seen) begin
          mismatch_cnt++;
          if (mismatch_cnt <= SHOWN_MISMATCHES)
            $display("%0t: speed mismatch exp L=%0d R=%0d stop=%0b got L=%0d R=%0d stop=%0b",
                     $time, want.left_speed, want.right_speed, want.stop_seen,
                     spd_ch.left_speed, spd_ch.right_speed, spd_ch.stop_seen);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
          (spd_ch.valid === 1'b1 && spd_ch.ready === 1'b1) || cfg_we === 1'b1)
        idle = 0;
      else
        idle++;
    end
    $display("camera_line_follow_speed_tb failed");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_FRAME_WIDTH;
    cfg_wdata         <= '0;
    pix_ch.valid      <= 1'b0;
    pix_ch.pix_col    <= '0;
    pix_ch.pix_row    <= '0;
    pix_ch.chan_red   <= '0;
    pix_ch.chan_green <= '0;
    pix_ch.chan_blue  <= '0;
    pix_ch.frame_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_frame();
    test_stop_line();
    test_outside_frame();
    test_register_extremes();
    test_output_backpressure();
    test_random_frames();
    wait_results_done();
    if (mismatch_cnt == 0) begin
      $display("camera_line_follow_speed_tb passed");
    end else begin
      $display("camera_line_follow_speed_tb failed");
    end
    $finish;
  end

endmodule
